/* design/sobel_pkg.sv */
package sobel_pkg;

   localparam int PIX_W             = 8;
   localparam int WIDTH_REG_W       = 11;
   localparam int HEIGHT_REG_W      = 13;
   localparam int CSR_DATA_W        = 13;
   localparam int CSR_INDEX_W       = 4;
   localparam int ROW_W             = 12;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MIN_FRAME_DIM     = 3;
   localparam int MAX_HEIGHT        = 4096;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;

   localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 4'd0,
      CSR_FRAME_HEIGHT = 4'd1
   } csr_index_type;

   // per-pixel control that rides along with the line-store read
   typedef struct packed {
      logic emit;   // closes the window of an interior pixel, produces a transaction
      logic last;   // final pixel of the frame
   } pix_ctl_type;

endpackage

/* design/sobel_ram.sv */
module sobel_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/sobel_line_buf.sv */
module sobel_line_buf #(
   parameter int MaxWidth = sobel_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sobel_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sobel_pkg::PIX_W-1:0]         req_pixel,
   output logic                                s1_valid,
   output sobel_pkg::pix_ctl_type              s1_ctl,
   output logic [sobel_pkg::PIX_W-1:0]         s1_pixel,
   output logic [sobel_pkg::PIX_W-1:0]         s1_up1,
   output logic [sobel_pkg::PIX_W-1:0]         s1_up2,
   input  logic                                s1_advance
);

   localparam int ColW = $clog2(MaxWidth);
   localparam int PixW = sobel_pkg::PIX_W;
   localparam int RowW = sobel_pkg::ROW_W;
   localparam int WidthResetEff =
      (sobel_pkg::WIDTH_RESET > MaxWidth) ? MaxWidth : sobel_pkg::WIDTH_RESET;
   localparam logic [ColW-1:0] WidthLastReset = ColW'(WidthResetEff - 1);
   localparam logic [RowW-1:0] HeightLastReset = RowW'(sobel_pkg::HEIGHT_RESET - 1);

   logic [ColW-1:0] width_last_ff, width_last_in;
   logic [RowW-1:0] height_last_ff, height_last_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic            s1_valid_ff, s1_valid_in;
   logic [PixW-1:0] s1_pixel_ff;
   logic [ColW-1:0] s1_col_ff;
   sobel_pkg::pix_ctl_type s1_ctl_ff, s1_ctl_in;

   logic [sobel_pkg::CSR_DATA_W-1:0] w_val, h_val;
   logic            accept;
   logic            col_wrap;
   logic [2*PixW-1:0] ram_rdata;
   logic [2*PixW-1:0] ram_wdata;
   logic              ram_we;

   assign req_ready = !s1_valid_ff || s1_advance;
   assign accept    = req_valid && req_ready;
   assign col_wrap  = (col_ff == width_last_ff);

   assign w_val = sobel_pkg::CSR_DATA_W'(csr_wdata[sobel_pkg::WIDTH_REG_W-1:0]);
   assign h_val = csr_wdata[sobel_pkg::HEIGHT_REG_W-1:0];

   // clamp the written size and keep it as "last index"
   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_we) begin
         unique case (csr_index)
            sobel_pkg::CSR_FRAME_WIDTH: begin
               if (w_val < sobel_pkg::MIN_FRAME_DIM) begin
                  width_last_in = ColW'(sobel_pkg::MIN_FRAME_DIM - 1);
               end else if (w_val > MaxWidth) begin
                  width_last_in = ColW'(MaxWidth - 1);
               end else begin
                  width_last_in = ColW'(w_val - 1'b1);
               end
            end
            sobel_pkg::CSR_FRAME_HEIGHT: begin
               if (h_val < sobel_pkg::MIN_FRAME_DIM) begin
                  height_last_in = RowW'(sobel_pkg::MIN_FRAME_DIM - 1);
               end else if (h_val > sobel_pkg::MAX_HEIGHT) begin
                  height_last_in = RowW'(sobel_pkg::MAX_HEIGHT - 1);
               end else begin
                  height_last_in = RowW'(h_val - 1'b1);
               end
            end
            default: begin
               width_last_in  = width_last_ff;
               height_last_in = height_last_ff;
            end
         endcase
      end
   end

   // raster position; any register write restarts the frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = (row_ff == height_last_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in    = accept || (s1_valid_ff && !s1_advance);
      s1_ctl_in.emit = (row_ff >= RowW'(2)) && (col_ff >= ColW'(2));
      s1_ctl_in.last = col_wrap && (row_ff == height_last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= WidthLastReset;
         height_last_ff <= HeightLastReset;
         col_ff         <= '0;
         row_ff         <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_ff;
         s1_ctl_ff   <= s1_ctl_in;
      end
   end

   // low byte: previous row, high byte: row before that.
   // Write-back lands after the read, once the held pixel moves on; the next read is always a
   // different column (width >= 3), so no forwarding path is needed.
   assign ram_we    = s1_valid_ff && s1_advance;
   assign ram_wdata = {ram_rdata[PixW-1:0], s1_pixel_ff};

   sobel_ram #(
      .Width (2 * PixW),
      .Depth (MaxWidth)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_col_ff),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   assign s1_valid = s1_valid_ff;
   assign s1_ctl   = s1_ctl_ff;
   assign s1_pixel = s1_pixel_ff;
   assign s1_up1   = ram_rdata[PixW-1:0];
   assign s1_up2   = ram_rdata[2*PixW-1:PixW];

endmodule

/* design/sobel_grad.sv */
module sobel_grad (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         s1_valid,
   input  sobel_pkg::pix_ctl_type       s1_ctl,
   input  logic [sobel_pkg::PIX_W-1:0]  s1_pixel,
   input  logic [sobel_pkg::PIX_W-1:0]  s1_up1,
   input  logic [sobel_pkg::PIX_W-1:0]  s1_up2,
   output logic                         s1_advance,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sobel_pkg::PIX_W-1:0]  rsp_grad_rows,
   output logic [sobel_pkg::PIX_W-1:0]  rsp_grad_cols,
   output logic [sobel_pkg::PIX_W-1:0]  rsp_edge_res,
   output logic                         rsp_frame_last
);

   localparam int PixW = sobel_pkg::PIX_W;

   // |(a + 2b + c) - (d + 2e + f)|, clamped to 255
   function automatic logic [PixW-1:0] abs_diff_sat(
      input logic [PixW-1:0] a, input logic [PixW-1:0] b, input logic [PixW-1:0] c,
      input logic [PixW-1:0] d, input logic [PixW-1:0] e, input logic [PixW-1:0] f);
      logic [PixW+1:0] p;
      logic [PixW+1:0] n;
      logic [PixW+1:0] m;
      p = (PixW+2)'(a) + {1'b0, b, 1'b0} + (PixW+2)'(c);
      n = (PixW+2)'(d) + {1'b0, e, 1'b0} + (PixW+2)'(f);
      m = (p >= n) ? (p - n) : (n - p);
      return (m > (PixW+2)'(sobel_pkg::SAT_MAX)) ? sobel_pkg::SAT_MAX : m[PixW-1:0];
   endfunction

   logic [PixW-1:0] win_ff [3][3];   // [row][col], row 0 = oldest line
   logic            s2_valid_ff, s2_valid_in, s2_last_ff;
   logic            s3_valid_ff, s3_valid_in, s3_last_ff;
   logic [PixW-1:0] s3_gr_ff, s3_gc_ff;
   logic            out_valid_ff, out_valid_in, out_last_ff;
   logic [PixW-1:0] out_gr_ff, out_gc_ff, out_sum_ff;
   logic            s2_ready, s3_ready, out_ready;
   logic            win_shift;
   logic [PixW-1:0] gr, gc;
   logic [PixW:0]   sum;

   assign out_ready  = !out_valid_ff || rsp_ready;
   assign s3_ready   = !s3_valid_ff || out_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_advance = s2_ready;
   assign win_shift  = s1_valid && s2_ready;

   // border pixels still shift the window but put no valid result into the pipe
   always_comb begin
      s2_valid_in  = s2_ready  ? (s1_valid && s1_ctl.emit) : s2_valid_ff;
      s3_valid_in  = s3_ready  ? s2_valid_ff : s3_valid_ff;
      out_valid_in = out_ready ? s3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= s1_up2;
         win_ff[1][2] <= s1_up1;
         win_ff[2][2] <= s1_pixel;
         s2_last_ff   <= s1_ctl.last;
      end
   end

   assign gr = abs_diff_sat(win_ff[2][0], win_ff[2][1], win_ff[2][2],
                            win_ff[0][0], win_ff[0][1], win_ff[0][2]);
   assign gc = abs_diff_sat(win_ff[0][2], win_ff[1][2], win_ff[2][2],
                            win_ff[0][0], win_ff[1][0], win_ff[2][0]);

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_gr_ff   <= gr;
         s3_gc_ff   <= gc;
         s3_last_ff <= s2_last_ff;
      end
   end

   assign sum = (PixW+1)'(s3_gr_ff) + (PixW+1)'(s3_gc_ff);

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_gr_ff   <= s3_gr_ff;
         out_gc_ff   <= s3_gc_ff;
         out_sum_ff  <= sum[PixW] ? sobel_pkg::SAT_MAX : sum[PixW-1:0];
         out_last_ff <= s3_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_grad_rows  = out_gr_ff;
   assign rsp_grad_cols  = out_gc_ff;
   assign rsp_edge_res   = out_sum_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

/* design/sobel_edge_magnitude_core.sv */
// Sobel 3x3 edge magnitude on a raster stream of 8-bit grayscale pixels.
//
// Input channel (req_*): one pixel per transaction, row by row. The frame
// size comes from csr_index 0 (frame_width, clamped to 3..MaxWidth) and
// csr_index 1 (frame_height, clamped to 3..4096). Any csr write, also to an
// unused index, restarts the frame at row 0, column 0; write only while idle.
// Output channel (rsp_*): one transaction per interior pixel, carrying both
// absolute gradients (each clamped to 255), their clamped sum and a flag on
// the last interior pixel of the frame. Border pixels produce nothing.
//
// Throughput: one pixel per clock unless rsp_ready stalls the pipe. The line
// stores share one dual-port RAM (one read, one write a cycle); the read of
// the next column overlaps the write-back of the current one.
// Pipeline: RAM read on the accepting edge, then window, gradients and output
// register, in that order, before rsp_valid rises.
// Stall: rsp_ready low fills the three-deep result pipe; req_ready drops only
// once it is full and the pixel held after the RAM read cannot move on.
// Reset: frame size 640x480, position at the frame start, pipe empty. The
// line RAM is not cleared; the first two rows fill it before any use.
module sobel_edge_magnitude_core #(
   parameter int MaxWidth = sobel_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sobel_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sobel_pkg::PIX_W-1:0]        req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sobel_pkg::PIX_W-1:0]        rsp_grad_rows,
   output logic [sobel_pkg::PIX_W-1:0]        rsp_grad_cols,
   output logic [sobel_pkg::PIX_W-1:0]        rsp_edge_res,
   output logic                               rsp_frame_last
);

   // pixel plus the two line-store bytes above it, registered on accept
   logic                         s1_valid;
   logic                         s1_advance;
   sobel_pkg::pix_ctl_type       s1_ctl;
   logic [sobel_pkg::PIX_W-1:0]  s1_pixel;
   logic [sobel_pkg::PIX_W-1:0]  s1_up1;
   logic [sobel_pkg::PIX_W-1:0]  s1_up2;

   // frame counters, csr, line RAM read / write-back
   sobel_line_buf #(
      .MaxWidth (MaxWidth)
   ) u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .s1_valid   (s1_valid),
      .s1_ctl     (s1_ctl),
      .s1_pixel   (s1_pixel),
      .s1_up1     (s1_up1),
      .s1_up2     (s1_up2),
      .s1_advance (s1_advance)
   );

   // 3x3 window, gradients, clamped sum, output register
   sobel_grad u_grad (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid),
      .s1_ctl         (s1_ctl),
      .s1_pixel       (s1_pixel),
      .s1_up1         (s1_up1),
      .s1_up2         (s1_up2),
      .s1_advance     (s1_advance),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_grad_rows  (rsp_grad_rows),
      .rsp_grad_cols  (rsp_grad_cols),
      .rsp_edge_res   (rsp_edge_res),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

/* design/sobel_edge_magnitude_checker.sv */
module sobel_edge_magnitude_sva (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [sobel_pkg::PIX_W-1:0]        rsp_grad_rows,
   input  logic [sobel_pkg::PIX_W-1:0]        rsp_grad_cols,
   input  logic [sobel_pkg::PIX_W-1:0]        rsp_edge_res,
   input  logic                               rsp_frame_last
);

   logic [sobel_pkg::PIX_W:0] grad_sum;

   assign grad_sum = (sobel_pkg::PIX_W+1)'(rsp_grad_rows)
                   + (sobel_pkg::PIX_W+1)'(rsp_grad_cols);

   // pipe comes out of reset empty and ready for a pixel
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("pipe not empty right after reset");

   // result transaction holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_grad_rows) && $stable(rsp_grad_cols)
                                  && $stable(rsp_edge_res) && $stable(rsp_frame_last))
      else $error("rsp payload changed while stalled");

   // magnitude is the clamped sum of the two gradients
   a_sum_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (grad_sum[sobel_pkg::PIX_W]
                     ? (rsp_edge_res == sobel_pkg::SAT_MAX)
                     : (rsp_edge_res == grad_sum[sobel_pkg::PIX_W-1:0])))
      else $error("edge magnitude is not the clamped gradient sum");

endmodule

bind sobel_edge_magnitude_core sobel_edge_magnitude_sva u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_grad_rows  (rsp_grad_rows),
   .rsp_grad_cols  (rsp_grad_cols),
   .rsp_edge_res   (rsp_edge_res),
   .rsp_frame_last (rsp_frame_last)
);
